FILE: rtl/assert_macros.svh
// assertion helpers shared by the blur blocks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression that must never be true outside reset
`define ASSERT_NEVER(lbl, expr, msg) \
    `ASSERT_RST(lbl, !(expr), msg)

`endif

FILE: rtl/bb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb_pkg
// types, constants and arithmetic helpers of the 3x3 rgb box blur
// ----------------------------------------------------------------------------
package bb_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int PIX_W      = 24;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int SUM_W      = 12;
    localparam int RCP_W      = 17;
    localparam int CNT_W      = 4;

    typedef enum logic
    {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } cfg_idx_t;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed
    {
        pix_t [8:0]       win;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [FW_W-1:0]  width;
        logic [FH_W-1:0]  height;
    } job_t;

    typedef enum logic
    {
        F_IDLE,
        F_UPD
    } front_state_t;

    typedef enum logic [2:0]
    {
        B_IDLE,
        B_SUM,
        B_MUL,
        B_FIX,
        B_OUT
    } back_state_t;

    // floor(2^16 / cnt) for the counts a 3x3 window can have
    function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RCP_W-1:0] r;
        begin
            case (cnt)
                4'd2:    r = 17'd32768;
                4'd3:    r = 17'd21845;
                4'd4:    r = 17'd16384;
                4'd6:    r = 17'd10922;
                4'd9:    r = 17'd7281;
                default: r = 17'd65536;
            endcase
            return r;
        end
    endfunction

    // q * cnt by shifts and adds
    function automatic logic [15:0] cnt_mul(input logic [SUM_W-1:0] q,
                                            input logic [CNT_W-1:0] cnt);
        logic [15:0] qe;
        logic [15:0] p;
        begin
            qe = {4'b0, q};
            case (cnt)
                4'd2:    p = qe << 1;
                4'd3:    p = qe + (qe << 1);
                4'd4:    p = qe << 2;
                4'd6:    p = (qe << 2) + (qe << 1);
                4'd9:    p = (qe << 3) + qe;
                default: p = qe;
            endcase
            return p;
        end
    endfunction

endpackage

FILE: rtl/box_blur_3x3_rgb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// streaming 3x3 box blur of an rgb frame in raster order
// ----------------------------------------------------------------------------
// The front end takes a pixel beat while its line stores start the registered
// read, and updates window and stores in its update state before it takes the
// next beat; each window then gives 0 to 4 blurred pixels in the averaging back
// end. The back end picks a window up in its idle state and steps through sum,
// reciprocal multiply, correction and output register for each of its results;
// a window with no result leaves the queue as it is picked up. A two-entry
// window queue between them lets both sides stall independently. Without output
// stalls the back end sets the pace inside the frame, with extra results at row
// and frame ends; the first row, which gives no results unless it is the only
// row, runs at the front end's pace. Output (r-1,c-1) follows input (r,c);
// geometry comes from frame_width (index 0) and frame_height (index 1).
module box_blur_3x3_rgb (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [12:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // in_red, in_green, in_blue
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_red, out_green, out_blue, out_row, out_col
    output logic        m_tlast
);

    logic         push;
    bb_pkg::job_t push_job;
    logic         q_full;
    logic         q_valid;
    logic         pop;
    bb_pkg::job_t head;

    bb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job)
    );

    bb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .valid    (q_valid),
        .head     (head)
    );

    bb_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: rtl/bb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/bb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb_queue
// short job queue between the pixel front end and the averaging back end
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bb_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  bb_pkg::job_t push_job,
    output logic         full,
    input  logic         pop,
    output logic         valid,
    output bb_pkg::job_t head
);

    bb_pkg::job_t                   slot_reg [bb_pkg::QDEPTH];
    logic [bb_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [bb_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [bb_pkg::QCNT_W-1:0]      count_reg;
    logic [bb_pkg::QCNT_W-1:0]      count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign full  = (count_reg == bb_pkg::QCNT_W'(bb_pkg::QDEPTH));
    assign valid = (count_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];

    `ASSERT_NEVER(a_no_overflow, push && full, "job queue overflow")
    `ASSERT_NEVER(a_no_underflow, pop && !valid, "job queue underflow")

endmodule

FILE: rtl/bb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb_front
// takes pixels, tracks the raster position, keeps line stores and window
// ----------------------------------------------------------------------------
module bb_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_addr,
    input  logic [bb_pkg::FH_W-1:0]   cfg_wdata,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [23:0]               s_tdata,   // red, green, blue
    input  logic                      q_full,
    output logic                      push,
    output bb_pkg::job_t              push_job
);

    bb_pkg::front_state_t           state_reg;
    bb_pkg::front_state_t           state_next;
    logic [bb_pkg::FW_W-1:0]        fw_reg;
    logic [bb_pkg::FH_W-1:0]        fh_reg;
    logic [bb_pkg::ROW_W-1:0]       row_reg;
    logic [bb_pkg::ROW_W-1:0]       row_next;
    logic [bb_pkg::COL_W-1:0]       col_reg;
    logic [bb_pkg::COL_W-1:0]       col_next;
    logic [bb_pkg::ROW_W-1:0]       r_cur_reg;
    logic [bb_pkg::COL_W-1:0]       c_cur_reg;
    bb_pkg::pix_t                   pix_reg;
    bb_pkg::pix_t [8:0]             win_reg;
    bb_pkg::pix_t [8:0]             win_next;
    logic [bb_pkg::FW_W-1:0]        w_eff;
    logic [bb_pkg::FH_W-1:0]        h_eff;
    logic                           accept;
    logic [bb_pkg::ROW_W-1:0]       r_start;
    logic [bb_pkg::COL_W-1:0]       c_start;
    logic [bb_pkg::FH_W-1:0]        r_tmp;
    logic [bb_pkg::FW_W-1:0]        c_inc;
    logic [bb_pkg::FH_W-1:0]        r_inc;
    bb_pkg::pix_t                   above_rd;
    bb_pkg::pix_t                   two_rd;
    bb_pkg::pix_t                   pix_in;

    // clamp the geometry to what the stores support
    always_comb
    begin
        if (fw_reg == '0)
        begin
            w_eff = bb_pkg::FW_W'(1);
        end
        else if (fw_reg > bb_pkg::FW_W'(bb_pkg::MAX_WIDTH))
        begin
            w_eff = bb_pkg::FW_W'(bb_pkg::MAX_WIDTH);
        end
        else
        begin
            w_eff = fw_reg;
        end
        if (fh_reg == '0)
        begin
            h_eff = bb_pkg::FH_W'(1);
        end
        else if (fh_reg > bb_pkg::FH_W'(bb_pkg::MAX_HEIGHT))
        begin
            h_eff = bb_pkg::FH_W'(bb_pkg::MAX_HEIGHT);
        end
        else
        begin
            h_eff = fh_reg;
        end
    end

    assign pix_in = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};

    // position of the incoming beat, re-aligned if the geometry shrank
    always_comb
    begin
        if ({1'b0, col_reg} >= w_eff)
        begin
            c_start = '0;
            r_tmp   = {1'b0, row_reg} + 1'b1;
        end
        else
        begin
            c_start = col_reg;
            r_tmp   = {1'b0, row_reg};
        end
        if (r_tmp >= h_eff)
        begin
            r_start = '0;
        end
        else
        begin
            r_start = r_tmp[bb_pkg::ROW_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        push       = 1'b0;
        case (state_reg)
            bb_pkg::F_IDLE:
            begin
                s_tready = !q_full;
                if (s_tvalid && !q_full)
                begin
                    state_next = bb_pkg::F_UPD;
                end
            end
            bb_pkg::F_UPD:
            begin
                push       = 1'b1;
                state_next = bb_pkg::F_IDLE;
            end
            default:
            begin
                state_next = bb_pkg::F_IDLE;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bb_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_next[i*3+0] = win_reg[i*3+1];
            win_next[i*3+1] = win_reg[i*3+2];
        end
        win_next[2] = two_rd;
        win_next[5] = above_rd;
        win_next[8] = pix_reg;
    end

    always_comb
    begin
        c_inc = {1'b0, c_cur_reg} + 1'b1;
        r_inc = {1'b0, r_cur_reg} + 1'b1;
        if (c_inc >= w_eff)
        begin
            col_next = '0;
            row_next = (r_inc >= h_eff) ? '0 : r_inc[bb_pkg::ROW_W-1:0];
        end
        else
        begin
            col_next = c_inc[bb_pkg::COL_W-1:0];
            row_next = r_cur_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg  <= bb_pkg::FW_W'(640);
            fh_reg  <= bb_pkg::FH_W'(480);
            row_reg <= '0;
            col_reg <= '0;
            win_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    bb_pkg::CFG_WIDTH:  fw_reg <= cfg_wdata[bb_pkg::FW_W-1:0];
                    bb_pkg::CFG_HEIGHT: fh_reg <= cfg_wdata;
                    default:            fw_reg <= fw_reg;
                endcase
            end
            if (push)
            begin
                win_reg <= win_next;
                row_reg <= row_next;
                col_reg <= col_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            r_cur_reg <= r_start;
            c_cur_reg <= c_start;
            pix_reg   <= pix_in;
        end
    end

    bb_ram #(
        .WIDTH (bb_pkg::PIX_W),
        .DEPTH (bb_pkg::MAX_WIDTH)
    ) u_line_above (
        .clk   (clk),
        .we    (push),
        .waddr (c_cur_reg),
        .wdata (pix_reg),
        .re    (accept),
        .raddr (c_start),
        .rdata (above_rd)
    );

    bb_ram #(
        .WIDTH (bb_pkg::PIX_W),
        .DEPTH (bb_pkg::MAX_WIDTH)
    ) u_line_two_above (
        .clk   (clk),
        .we    (push),
        .waddr (c_cur_reg),
        .wdata (above_rd),
        .re    (accept),
        .raddr (c_start),
        .rdata (two_rd)
    );

    assign push_job.win    = win_next;
    assign push_job.row    = r_cur_reg;
    assign push_job.col    = c_cur_reg;
    assign push_job.width  = w_eff;
    assign push_job.height = h_eff;

endmodule

FILE: rtl/bb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb_back
// walks the results of one window, averages and drives the output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bb_back (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  bb_pkg::job_t head,
    output logic         pop,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,   // red, green, blue, row, col, zero pad
    output logic         m_tlast
);

    bb_pkg::back_state_t            state_reg;
    bb_pkg::back_state_t            state_next;
    logic                           rsel_reg;
    logic                           rsel_next;
    logic                           csel_reg;
    logic                           csel_next;
    logic                           rv0;
    logic                           rv1;
    logic                           cv0;
    logic                           cv1;
    logic                           last_c;
    logic [2:0]                     rok;
    logic [2:0]                     cok;
    logic [13:0]                    rr;
    logic [11:0]                    cc;
    logic [bb_pkg::SUM_W-1:0]       sum_c [3];
    logic [bb_pkg::CNT_W-1:0]       cnt_c;
    logic [bb_pkg::SUM_W-1:0]       sum_reg [3];
    logic [bb_pkg::CNT_W-1:0]       cnt_reg;
    logic [bb_pkg::ROW_W-1:0]       orow_reg;
    logic [bb_pkg::COL_W-1:0]       ocol_reg;
    logic                           last_reg;
    logic [bb_pkg::SUM_W-1:0]       x_reg [3];
    logic [bb_pkg::SUM_W-1:0]       q0_reg [3];
    logic [7:0]                     avg_reg [3];
    logic [bb_pkg::SUM_W-1:0]       x_c [3];
    logic [28:0]                    prod_c [3];
    logic [15:0]                    qc_c [3];
    logic [bb_pkg::SUM_W-1:0]       q_c [3];
    logic                           load;
    logic                           m_tvalid_reg;
    logic [47:0]                    m_tdata_reg;
    logic                           m_tlast_reg;

    assign rv0 = (head.row != '0);
    assign rv1 = ({1'b0, head.row} == head.height - 1'b1);
    assign cv0 = (head.col != '0);
    assign cv1 = ({1'b0, head.col} == head.width - 1'b1);
    assign last_c = (rsel_reg || !rv1) && (csel_reg || !cv1);

    // neighbors that are inside the frame and around the output position
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            rr = {2'b0, head.row} + 14'(k);
            rok[k] = (rr >= 14'd2) && (rr < {1'b0, head.height} + 14'd2)
                     && (!rsel_reg || k != 0);
            cc = {2'b0, head.col} + 12'(k);
            cok[k] = (cc >= 12'd2) && (cc < {1'b0, head.width} + 12'd2)
                     && (!csel_reg || k != 0);
        end
    end

    always_comb
    begin
        cnt_c = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            sum_c[ch] = '0;
        end
        for (int i = 0; i < 9; i++)
        begin
            if (rok[i/3] && cok[i%3])
            begin
                cnt_c    = cnt_c + 1'b1;
                sum_c[0] = sum_c[0] + {4'b0, head.win[i][23:16]};
                sum_c[1] = sum_c[1] + {4'b0, head.win[i][15:8]};
                sum_c[2] = sum_c[2] + {4'b0, head.win[i][7:0]};
            end
        end
    end

    // round half up: floor((2s+n)/(2n)) = floor((s + n/2) / n)
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            x_c[ch]    = sum_reg[ch] + bb_pkg::SUM_W'(cnt_reg >> 1);
            prod_c[ch] = 29'(x_c[ch]) * 29'(bb_pkg::recip(cnt_reg));
            qc_c[ch]   = bb_pkg::cnt_mul(q0_reg[ch], cnt_reg);
            if ({4'b0, x_reg[ch]} >= qc_c[ch] + 16'(cnt_reg))
            begin
                q_c[ch] = q0_reg[ch] + 1'b1;
            end
            else
            begin
                q_c[ch] = q0_reg[ch];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rsel_next  = rsel_reg;
        csel_next  = csel_reg;
        pop        = 1'b0;
        load       = 1'b0;
        case (state_reg)
            bb_pkg::B_IDLE:
            begin
                if (q_valid)
                begin
                    if (!(rv0 || rv1) || !(cv0 || cv1))
                    begin
                        pop = 1'b1;
                    end
                    else
                    begin
                        rsel_next  = !rv0;
                        csel_next  = !cv0;
                        state_next = bb_pkg::B_SUM;
                    end
                end
            end
            bb_pkg::B_SUM:
            begin
                state_next = bb_pkg::B_MUL;
                if (last_c)
                begin
                    pop = 1'b1;
                end
                else if (!csel_reg && cv1)
                begin
                    csel_next = 1'b1;
                end
                else
                begin
                    rsel_next = 1'b1;
                    csel_next = !cv0;
                end
            end
            bb_pkg::B_MUL:
            begin
                state_next = bb_pkg::B_FIX;
            end
            bb_pkg::B_FIX:
            begin
                state_next = bb_pkg::B_OUT;
            end
            bb_pkg::B_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    load       = 1'b1;
                    state_next = last_reg ? bb_pkg::B_IDLE : bb_pkg::B_SUM;
                end
            end
            default:
            begin
                state_next = bb_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bb_pkg::B_IDLE;
            rsel_reg     <= 1'b0;
            csel_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rsel_reg  <= rsel_next;
            csel_reg  <= csel_next;
            if (load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == bb_pkg::B_SUM)
        begin
            sum_reg  <= sum_c;
            cnt_reg  <= cnt_c;
            orow_reg <= rsel_reg ? head.row : head.row - 1'b1;
            ocol_reg <= csel_reg ? head.col : head.col - 1'b1;
            last_reg <= last_c;
        end
        if (state_reg == bb_pkg::B_MUL)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                x_reg[ch]  <= x_c[ch];
                q0_reg[ch] <= prod_c[ch][27:16];
            end
        end
        if (state_reg == bb_pkg::B_FIX)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                avg_reg[ch] <= q_c[ch][7:0];
            end
        end
        if (load)
        begin
            m_tdata_reg <= {2'b0, ocol_reg, orow_reg, avg_reg[2], avg_reg[1], avg_reg[0]};
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `ASSERT_RST(a_sum_has_job, (state_reg == bb_pkg::B_SUM) |-> q_valid,
                "result walk without a queued window")

endmodule

FILE: bench/box_blur_3x3_rgb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_checker
// watches the pixel, result and register ports of the box blur, computes
// the expected blurred pixels with its own line stores and window, and
// compares every result beat field by field against the oldest expectation
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [12:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);

    typedef struct packed
    {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] row;
        logic [9:0]  col;
        logic        last;
    } blur_pix_t;

    // pixels are held as {red, green, blue}
    logic [23:0]  row_above [bb_pkg::MAX_WIDTH];
    logic [23:0]  row_two_above [bb_pkg::MAX_WIDTH];
    logic [23:0]  win [9];
    int           next_row;
    int           next_col;
    logic [10:0]  width_reg;
    logic [12:0]  height_reg;
    blur_pix_t    blurred_q[$];

    assign pending = blurred_q.size();

    function automatic blur_pix_t blur_at(int orow, int ocol, int r, int c, int w, int h);
        int sr;
        int sg;
        int sb;
        int cnt;
        int nr;
        int nc;
        int wr;
        int wc;
        blur_pix_t p;
        sr = 0; sg = 0; sb = 0; cnt = 0;
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dc = -1; dc <= 1; dc++)
            begin
                nr = orow + dr;
                nc = ocol + dc;
                wr = nr - (r - 2);
                wc = nc - (c - 2);
                if (nr >= 0 && nr < h && nc >= 0 && nc < w &&
                    wr >= 0 && wr <= 2 && wc >= 0 && wc <= 2)
                begin
                    sr += win[wr*3+wc][23:16];
                    sg += win[wr*3+wc][15:8];
                    sb += win[wr*3+wc][7:0];
                    cnt++;
                end
            end
        end
        if (cnt == 0)
            cnt = 1;
        p.red   = 8'((2*sr + cnt) / (2*cnt));
        p.green = 8'((2*sg + cnt) / (2*cnt));
        p.blue  = 8'((2*sb + cnt) / (2*cnt));
        p.row   = 12'(orow);
        p.col   = 10'(ocol);
        p.last  = 1'b0;
        return p;
    endfunction

    task automatic take_pixel(input logic [23:0] beat);
        int w;
        int h;
        int r;
        int c;
        int rows[$];
        int cols[$];
        blur_pix_t p;
        w = (width_reg == 0) ? 1 :
            (width_reg > bb_pkg::MAX_WIDTH) ? bb_pkg::MAX_WIDTH : int'(width_reg);
        h = (height_reg == 0) ? 1 :
            (height_reg > bb_pkg::MAX_HEIGHT) ? bb_pkg::MAX_HEIGHT : int'(height_reg);
        if (next_col >= w)
        begin
            next_col = 0;
            next_row++;
        end
        if (next_row >= h)
            next_row = 0;
        r = next_row;
        c = next_col;
        for (int i = 0; i < 3; i++)
        begin
            win[i*3]   = win[i*3+1];
            win[i*3+1] = win[i*3+2];
        end
        win[2] = row_two_above[c];
        win[5] = row_above[c];
        win[8] = {beat[7:0], beat[15:8], beat[23:16]};
        row_two_above[c] = row_above[c];
        row_above[c] = win[8];
        if (r >= 1) rows.push_back(r - 1);
        if (r == h - 1) rows.push_back(r);
        if (c >= 1) cols.push_back(c - 1);
        if (c == w - 1) cols.push_back(c);
        foreach (rows[i])
        begin
            foreach (cols[j])
            begin
                p = blur_at(rows[i], cols[j], r, c, w, h);
                p.last = (i == rows.size() - 1) && (j == cols.size() - 1);
                blurred_q.push_back(p);
            end
        end
        next_col++;
        if (next_col >= w)
        begin
            next_col = 0;
            next_row++;
            if (next_row >= h)
                next_row = 0;
        end
    endtask

    task automatic check_result();
        blur_pix_t got;
        blur_pix_t want;
        got.red   = m_tdata[7:0];
        got.green = m_tdata[15:8];
        got.blue  = m_tdata[23:16];
        got.row   = m_tdata[35:24];
        got.col   = m_tdata[45:36];
        got.last  = m_tlast;
        if (blurred_q.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%t unexpected result beat %h last %b", $realtime, m_tdata, m_tlast);
        end
        else
        begin
            want = blurred_q.pop_front();
            if (got !== want || m_tdata[47:46] !== 2'b00)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display(
                        "%t got (%0d,%0d) %h %h %h %b want (%0d,%0d) %h %h %h %b",
                        $realtime, got.row, got.col, got.red, got.green, got.blue,
                        got.last, want.row, want.col, want.red, want.green, want.blue,
                        want.last);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bb_pkg::MAX_WIDTH; i++)
            begin
                row_above[i] = '0;
                row_two_above[i] = '0;
            end
            for (int i = 0; i < 9; i++)
                win[i] = '0;
            next_row   = 0;
            next_col   = 0;
            width_reg  = 11'd640;
            height_reg = 13'd480;
            fail_count = 0;
            blurred_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == bb_pkg::CFG_WIDTH)
                    width_reg = cfg_wdata[10:0];
                else
                    height_reg = cfg_wdata;
            end
            if (s_tvalid && s_tready)
                take_pixel(s_tdata);
            if (m_tvalid && m_tready)
                check_result();
        end
    end

endmodule

FILE: bench/box_blur_3x3_rgb_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_test
// drives whole frames of rgb pixels through the box blur at several frame
// sizes, including one-pixel frames and zero register values, with random
// source gaps and sink stalls; the checker judges every result beat
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_test;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_addr;
    logic [12:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tlast;
    int          fail_count;
    int          pending;
    bit          quiet;
    int          stall_left;
    int          pixel_total;

    box_blur_3x3_rgb dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    box_blur_3x3_rgb_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int idle_len();
        int k;
        k = $urandom_range(0, 99);
        if (quiet || k < 70)
            return 0;
        if (k < 96)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // sink stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            stall_left <= idle_len();
            m_tready   <= 1'b1;
        end
    end

    task automatic write_reg(input bb_pkg::cfg_idx_t idx, input logic [12:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue);
        bit taken;
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {blue, green, red};
        do
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end
        while (!taken);
        pixel_total++;
        gap = idle_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // one full frame; mode 0 random, 1 extremes only, 2 all zero, 3 all full
    task automatic send_frame(input logic [12:0] w_val, input logic [12:0] h_val,
                              input int w, input int h, input int mode);
        logic [7:0] v[3];
        drain();
        write_reg(bb_pkg::CFG_WIDTH, w_val);
        write_reg(bb_pkg::CFG_HEIGHT, h_val);
        for (int i = 0; i < w * h; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                case (mode)
                    1:       v[k] = $urandom_range(0, 1) ? 8'hff : 8'h00;
                    2:       v[k] = 8'h00;
                    3:       v[k] = 8'hff;
                    default: v[k] = 8'($urandom);
                endcase
            end
            send_pixel(v[0], v[1], v[2]);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_addr    = bb_pkg::CFG_WIDTH;
        cfg_wdata   = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        quiet       = 1'b0;
        pixel_total = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero registers mean a 1x1 frame, then small frames, most at value extremes
        send_frame(13'd0, 13'd0, 1, 1, 3);
        send_frame(13'd1, 13'd1, 1, 1, 0);
        send_frame(13'd3, 13'd3, 3, 3, 3);
        send_frame(13'd3, 13'd3, 3, 3, 1);
        send_frame(13'd2, 13'd3, 2, 3, 2);

        while (pixel_total < 470)
        begin
            int w;
            int h;
            quiet = ($urandom_range(0, 4) == 0);
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            send_frame(13'(w), 13'(h), w, h, ($urandom_range(0, 5) == 0) ? 1 : 0);
        end
        drain();

        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
